// File: sv/bfme_pkg.sv
// ----------------------------------------------------------------------------
// bfme_pkg
// Shared types and constants for the cubic curve fit error block.
// ----------------------------------------------------------------------------
package bfme_pkg;

    // Field widths that the stream format fixes
    localparam int U_W        = 17;
    localparam int ERR_W      = 36;
    localparam int IDX_W      = 10;
    localparam int M_DATA_W   = ((ERR_W + IDX_W + 7) / 8) * 8;

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CTRL_SEL_W = 3;
    localparam int NUM_CTRL   = 8;

    // Parameter value 1.0 in Q1.16
    localparam logic [U_W-1:0] U_ONE = 17'h10000;

    // Saturated squared error
    localparam logic [ERR_W-1:0] ERR_MAX = {ERR_W{1'b1}};

    // Shared multiplier: second operand is signed and holds the parameter
    // or an 18-bit distance magnitude
    localparam int SQ_W   = 18;
    localparam int MB_W   = SQ_W + 1;
    localparam int RND_HALF = 32768;
    localparam int Q_SHIFT  = 16;

    // Sequencer steps: twelve interpolations, then two squares
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] LERP_STEPS = 4'd12;
    localparam logic [STEP_W-1:0] ISSUE_LAST = 4'd13;
    localparam logic [STEP_W-1:0] CALC_LAST  = 4'd14;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_SUM,
        ST_UPDATE
    } state_t;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_LERP,
        OP_SQ_X,
        OP_SQ_Y
    } mul_op_t;

    // Tag that travels with each product through the multiplier
    typedef struct packed {
        mul_op_t    op;
        logic       axis;
        logic [1:0] slot;
        logic       sat;
    } mul_tag_t;

    // Slot written by each interpolation pair: three on the first level,
    // two on the second, one on the third
    function automatic logic [1:0] lerp_slot(input logic [2:0] pair);
        logic [1:0] slot;
        unique case (pair)
            3'd0:    slot = 2'd0;
            3'd1:    slot = 2'd1;
            3'd2:    slot = 2'd2;
            3'd3:    slot = 2'd0;
            3'd4:    slot = 2'd1;
            3'd5:    slot = 2'd0;
            default: slot = 2'd0;
        endcase
        return slot;
    endfunction

endpackage

// File: sv/bfme_mul_unit.sv
// ----------------------------------------------------------------------------
// bfme_mul_unit
// Shared signed multiplier with a registered product and a matching tag.
// ----------------------------------------------------------------------------
module bfme_mul_unit #(
    parameter int A_W = 19
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic signed [A_W-1:0]                 op_a,
    input  logic signed [bfme_pkg::MB_W-1:0]      op_b,
    input  bfme_pkg::mul_tag_t                    tag_in,
    output logic signed [A_W+bfme_pkg::MB_W-1:0]  prod_reg,
    output bfme_pkg::mul_tag_t                    tag_reg
);
    import bfme_pkg::*;

    // Register the product
    always_ff @(posedge clk)
    begin
        prod_reg <= op_a * op_b;
    end

    // Carry the tag alongside
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '{op: OP_NONE, axis: 1'b0, slot: 2'd0, sat: 1'b0};
        end
        else
        begin
            tag_reg <= tag_in;
        end
    end

endmodule

// File: sv/bezier_fit_max_error_top.sv
// ----------------------------------------------------------------------------
// bezier_fit_max_error_top
// Running maximum squared distance between points and a cubic curve.
// ----------------------------------------------------------------------------
// Usage:
//   Write the four control points through the cfg channel (index 0..7:
//   x0, y0, x1, y1, x2, y2, x3, y3) while the block is idle; cfg_ready is
//   always high and indexes above 7 are dropped.
//   Each s_ transaction carries one point and its curve parameter; the
//   block evaluates the cubic by de Casteljau interpolation on one shared
//   multiplier and keeps the largest squared distance and its position.
//   On a transaction with s_tlast set, one m_ transaction carries the
//   maximum and its position, and the running values clear.
// Timing:
//   After acceptance an item runs through 12 interpolations and 2
//   squares, issued back to back through the one multiplier, then the
//   last write back, the sum and the update. s_tready returns once the
//   update is done, so the block takes no new item before the last one
//   is through. A result is registered onto m_tvalid by the update of
//   its last item.
// Reset and stall:
//   Reset clears control points, running maximum, position and count.
//   A waiting result is held in the output register; the next item is
//   accepted and processed, and only a further last item waits in its
//   update cycle until the earlier result has been taken.
// ----------------------------------------------------------------------------
module bezier_fit_max_error_top #(
    parameter int MAX_POINTS  = 1024,
    parameter int COORD_WIDTH = 16
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // Configuration writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [bfme_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [COORD_WIDTH-1:0]                 cfg_data,
    // Input points
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // point_x, point_y, param_u, zero fill
    input  logic [((2*COORD_WIDTH+bfme_pkg::U_W+7)/8)*8-1:0] s_tdata,
    // is_last
    input  logic                                   s_tlast,
    // Results
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // max_sq_error, worst_index, zero fill
    output logic [bfme_pkg::M_DATA_W-1:0]          m_tdata
);
    import bfme_pkg::*;

    localparam int CW    = COORD_WIDTH;
    localparam int A_W   = (CW + 2 > MB_W) ? CW + 2 : MB_W;
    localparam int P_W   = A_W + MB_W;
    localparam int CNT_W = $clog2(MAX_POINTS);

    // ------------------------------------------------------------------
    // Declarations
    // ------------------------------------------------------------------
    state_t                  state_reg, state_next;
    logic [STEP_W-1:0]       step_reg, step_next;

    logic [CW-1:0]           ctrl_reg [NUM_CTRL];
    logic signed [CW-1:0]    q_reg [2][4];
    logic signed [CW-1:0]    p_reg [2];
    logic [U_W-1:0]          u_reg;
    logic                    last_reg;
    logic [ERR_W-1:0]        sqx_reg, sqy_reg, dist_reg;
    logic [ERR_W-1:0]        max_reg;
    logic [IDX_W-1:0]        worst_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    m_tvalid_reg;
    logic [M_DATA_W-1:0]     m_data_reg;

    logic                    accept;
    logic                    fire;
    logic [U_W-1:0]          in_u;
    logic [U_W-1:0]          in_u_clamp;

    logic                    iss_axis;
    logic [1:0]              iss_slot;
    logic signed [CW-1:0]    lo_val, hi_val;
    logic signed [A_W-1:0]   lo_ext, hi_ext, pt_ext, diff;
    logic [A_W-1:0]          mag;
    logic                    mag_sat;
    logic signed [A_W-1:0]   op_a;
    logic signed [MB_W-1:0]  op_b;
    mul_tag_t                tag_in, tag_reg;
    logic signed [P_W-1:0]   prod_reg;
    logic signed [P_W-1:0]   rnd, shifted;

    logic [ERR_W:0]          sum;
    logic [CNT_W-1:0]        cnt_inc;
    logic [IDX_W-1:0]        cnt_idx;
    logic                    hit;
    logic [ERR_W-1:0]        new_max;
    logic [IDX_W-1:0]        new_worst;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_CTRL; i++)
            begin
                ctrl_reg[i] <= '0;
            end
        end
        else if (cfg_valid && (cfg_index < CFG_IDX_W'(NUM_CTRL)))
        begin
            ctrl_reg[cfg_index[CTRL_SEL_W-1:0]] <= cfg_data;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // Hold a last item while an earlier result is still waiting
    assign fire = (state_reg == ST_UPDATE) && !(last_reg && m_tvalid_reg && !m_tready);

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    state_next = ST_CALC;
                    step_next  = '0;
                end
            end
            ST_CALC:
            begin
                step_next = step_reg + 1'b1;
                if (step_reg == CALC_LAST)
                begin
                    state_next = ST_SUM;
                end
            end
            ST_SUM:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign accept = s_tvalid && s_tready;

    // ------------------------------------------------------------------
    // Load the item and the control points
    // ------------------------------------------------------------------
    assign in_u       = s_tdata[2*CW+U_W-1:2*CW];
    assign in_u_clamp = (in_u > U_ONE) ? U_ONE : in_u;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            p_reg[0] <= s_tdata[CW-1:0];
            p_reg[1] <= s_tdata[2*CW-1:CW];
            u_reg    <= in_u_clamp;
            last_reg <= s_tlast;
        end
    end

    // ------------------------------------------------------------------
    // Operand selection for the shared multiplier
    // ------------------------------------------------------------------
    always_comb
    begin
        iss_axis = step_reg[0];
        iss_slot = lerp_slot(step_reg[3:1]);
        unique case (iss_slot)
            2'd0:
            begin
                lo_val = q_reg[iss_axis][0];
                hi_val = q_reg[iss_axis][1];
            end
            2'd1:
            begin
                lo_val = q_reg[iss_axis][1];
                hi_val = q_reg[iss_axis][2];
            end
            default:
            begin
                lo_val = q_reg[iss_axis][2];
                hi_val = q_reg[iss_axis][3];
            end
        endcase
        lo_ext  = A_W'(lo_val);
        hi_ext  = A_W'(hi_val);
        pt_ext  = A_W'(p_reg[iss_axis]);
        // Distance from the curve point (slot 0 holds the final value)
        diff    = A_W'(q_reg[iss_axis][0]) - pt_ext;
        mag     = diff[A_W-1] ? A_W'(-diff) : diff;
        mag_sat = |(mag >> SQ_W);

        op_a   = '0;
        op_b   = '0;
        tag_in = '{op: OP_NONE, axis: 1'b0, slot: 2'd0, sat: 1'b0};
        if ((state_reg == ST_CALC) && (step_reg < LERP_STEPS))
        begin
            op_a   = hi_ext - lo_ext;
            op_b   = MB_W'(u_reg);
            tag_in = '{op: OP_LERP, axis: iss_axis, slot: iss_slot, sat: 1'b0};
        end
        else if ((state_reg == ST_CALC) && (step_reg <= ISSUE_LAST))
        begin
            op_a   = A_W'(mag[SQ_W-1:0]);
            op_b   = MB_W'(mag[SQ_W-1:0]);
            tag_in = '{op: (iss_axis ? OP_SQ_Y : OP_SQ_X), axis: iss_axis,
                       slot: 2'd0, sat: mag_sat};
        end
    end

    bfme_mul_unit #(
        .A_W (A_W)
    ) u_mul (
        .clk      (clk),
        .rst_n    (rst_n),
        .op_a     (op_a),
        .op_b     (op_b),
        .tag_in   (tag_in),
        .prod_reg (prod_reg),
        .tag_reg  (tag_reg)
    );

    // ------------------------------------------------------------------
    // Write back: interpolate in place, or capture a square
    // ------------------------------------------------------------------
    assign rnd     = prod_reg + P_W'(RND_HALF);
    assign shifted = rnd >>> Q_SHIFT;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int k = 0; k < 4; k++)
            begin
                q_reg[0][k] <= ctrl_reg[2*k];
                q_reg[1][k] <= ctrl_reg[2*k+1];
            end
        end
        else if (tag_reg.op == OP_LERP)
        begin
            q_reg[tag_reg.axis][tag_reg.slot] <=
                q_reg[tag_reg.axis][tag_reg.slot] + shifted[CW-1:0];
        end

        if (tag_reg.op == OP_SQ_X)
        begin
            sqx_reg <= tag_reg.sat ? ERR_MAX : prod_reg[ERR_W-1:0];
        end
        if (tag_reg.op == OP_SQ_Y)
        begin
            sqy_reg <= tag_reg.sat ? ERR_MAX : prod_reg[ERR_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Sum the squares with saturation
    // ------------------------------------------------------------------
    assign sum = {1'b0, sqx_reg} + {1'b0, sqy_reg};

    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SUM)
        begin
            dist_reg <= sum[ERR_W] ? ERR_MAX : sum[ERR_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // Running maximum and position
    // ------------------------------------------------------------------
    assign cnt_inc = (cnt_reg != CNT_W'(MAX_POINTS - 1)) ? cnt_reg + 1'b1 : cnt_reg;

    generate
        if (CNT_W >= IDX_W)
        begin : g_idx_trunc
            assign cnt_idx = cnt_inc[IDX_W-1:0];
        end
        else
        begin : g_idx_ext
            assign cnt_idx = {{(IDX_W-CNT_W){1'b0}}, cnt_inc};
        end
    endgenerate

    assign hit       = dist_reg >= max_reg;
    assign new_max   = hit ? dist_reg : max_reg;
    assign new_worst = hit ? cnt_idx : worst_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg   <= '0;
            worst_reg <= '0;
            cnt_reg   <= '0;
        end
        else if (fire)
        begin
            if (last_reg)
            begin
                max_reg   <= '0;
                worst_reg <= '0;
                cnt_reg   <= '0;
            end
            else
            begin
                max_reg   <= new_max;
                worst_reg <= new_worst;
                cnt_reg   <= cnt_inc;
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (fire && last_reg)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && last_reg)
        begin
            m_data_reg <= {{(M_DATA_W-ERR_W-IDX_W){1'b0}}, new_worst, new_max};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_data_reg;

endmodule

// File: sv/bfme_checker.sv
// ----------------------------------------------------------------------------
// bfme_checker
// Port-level checks for the curve fit error block, bound to the top level.
// ----------------------------------------------------------------------------
module bfme_checker #(
    parameter int M_W = 48
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           s_tvalid,
    input  logic           s_tready,
    input  logic           m_tvalid,
    input  logic           m_tready,
    input  logic [M_W-1:0] m_tdata
);

    // A stalled result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed or dropped while stalled");

    // An item keeps the block busy for the next cycles
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready ##1 !s_tready)
        else $error("input taken again while an item is in work");

    // A new result only comes out of a finished computation
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without an item in work");

    // A result leaves only through a completed transaction
    a_out_leave: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_tvalid) |-> $past(m_tready))
        else $error("result withdrawn without a transaction");

endmodule

bind bezier_fit_max_error_top bfme_checker #(
    .M_W (bfme_pkg::M_DATA_W)
) u_bfme_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
